/* design/hde_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the histogram distance engine.
// No dependencies; imported by every module of the block.
package hde_pkg;

  localparam int MAX_BINS_DEF    = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int FIELD_W = 16;
  localparam int DIST_W  = 28;
  localparam int METRIC_W = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [METRIC_W-1:0] {
    MET_EUCLID    = 2'd0,
    MET_MANHATTAN = 2'd1,
    MET_CHEBYSHEV = 2'd2
  } metric_e;

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_SQRT = 3'b010,
    ST_FIN  = 3'b100
  } back_state_e;

  typedef struct packed {
    logic [FIELD_W-1:0] diff;
    logic               keep;
    logic               last;
    logic               ovf;
  } hde_item_t;

endpackage

/* design/histogram_distance_engine_unit.sv */
`timescale 1ns / 1ps
// Histogram distance engine, top level.
// Depends on hde_pkg, hde_front, hde_queue and hde_back.
//
// Usage:
//   s_axis: one bin pair per item; tlast marks the last pair of a vector.
//   m_axis: one distance item per vector, overflow flag in tuser.
//   cfg:    metric select write (0 euclidean, 1 manhattan, 2/3 chebyshev),
//           taken any cycle; write only while the block is idle.
// Throughput: one pair per cycle while the queue has room. At the end of a
// euclidean vector the back end runs a bit-per-cycle square root of
// (2*16 + clog2(MAX_BINS+1) + 1) / 2 steps (23 at the defaults) and then loads
// the output register; pairs keep entering the queue meanwhile until it fills.
// A manhattan or chebyshev result is loaded into the output register as the
// last pair leaves the queue; a euclidean result once the square root ends.
// Reset clears the accumulators, counters, queue pointers and control state
// and selects euclidean. When the receiver stalls, the result is held in the
// output register; the back end keeps accumulating the next vector and stalls
// only at its last pair, after which the queue fills and s_axis_tready drops.
module histogram_distance_engine_unit import hde_pkg::*; #(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // value_a [15:0], value_b [31:16]
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // distance [27:0], zeros [31:28]
  output logic                m_axis_tuser,   // overflow
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [METRIC_W-1:0] cfg_data_i
);

  logic [METRIC_W-1:0] metric_q;
  logic                push, push_ready;
  hde_item_t           push_item, head_item;
  logic                head_valid, pop;
  logic [DIST_W-1:0]   distance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= MET_EUCLID;
    end else if (cfg_valid_i) begin
      metric_q <= cfg_data_i;
    end
  end

  hde_front #(
    .MAX_BINS    (MAX_BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .value_a_i    (s_axis_tdata[15:0]),
    .value_b_i    (s_axis_tdata[31:16]),
    .last_i       (s_axis_tlast),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  hde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .din_i        (push_item),
    .pop_valid_o  (head_valid),
    .pop_i        (pop),
    .dout_o       (head_item)
  );

  hde_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .metric_i     (metric_q),
    .item_valid_i (head_valid),
    .pop_o        (pop),
    .item_i       (head_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .distance_o   (distance),
    .overflow_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0000, distance};

endmodule

/* design/hde_front.sv */
`timescale 1ns / 1ps
// Front end: accepts bin pairs, forms the absolute difference, counts pairs
// and classifies each item as kept or dropped. Depends on hde_pkg.
module hde_front import hde_pkg::*; #(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FIELD_W-1:0] value_a_i,
  input  logic [FIELD_W-1:0] value_b_i,
  input  logic               last_i,
  output logic               push_o,
  input  logic               push_ready_i,
  output hde_item_t          item_o
);

  localparam int CW = $clog2(MAX_BINS + 1);
  localparam int SB_EFF = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
  localparam logic [FIELD_W-1:0] SMASK = {FIELD_W{1'b1}} >> (FIELD_W - SB_EFF);

  logic [CW-1:0]      count_q, count_d;
  logic               ovf_q, ovf_d;
  logic [FIELD_W-1:0] a, b;
  logic               full;
  logic               acc;

  assign a    = value_a_i & SMASK;
  assign b    = value_b_i & SMASK;
  assign full = (count_q >= CW'(MAX_BINS));

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i;
  assign acc        = in_valid_i & push_ready_i;

  always_comb begin
    item_o.diff = (a >= b) ? (a - b) : (b - a);
    item_o.keep = ~full;
    item_o.last = last_i;
    item_o.ovf  = ovf_q | full;
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (acc) begin
      if (last_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

/* design/hde_queue.sv */
`timescale 1ns / 1ps
// Short item queue between front and back end.
// Depends on hde_pkg for the item type.
module hde_queue import hde_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      push_ready_o,
  input  hde_item_t din_i,
  output logic      pop_valid_o,
  input  logic      pop_i,
  output hde_item_t dout_o
);

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  hde_item_t       mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != (PW+1)'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;
  assign dout_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (do_push) begin
      wr_d = (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
    end
    cnt_d = cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/hde_back.sv */
`timescale 1ns / 1ps
// Back end: accumulates squared and absolute differences and the largest
// difference, runs the iterative square root and holds the result item.
// Depends on hde_pkg.
module hde_back import hde_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [METRIC_W-1:0] metric_i,
  input  logic                item_valid_i,
  output logic                pop_o,
  input  hde_item_t           item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DIST_W-1:0]   distance_o,
  output logic                overflow_o
);

  localparam int CW    = $clog2(MAX_BINS + 1);
  localparam int SW    = 2 * FIELD_W + CW;
  localparam int AW    = FIELD_W + CW;
  localparam int RW    = (SW + 1) / 2;
  localparam int REM_W = RW + 2;
  localparam int ITW   = $clog2(RW + 1);
  localparam int SQ_CW = ((RW > DIST_W) ? RW : DIST_W) + 1;
  localparam int AB_CW = ((AW > DIST_W) ? AW : DIST_W) + 1;

  back_state_e         state_q, state_d;
  logic [SW-1:0]       sq_q, sq_d, sq_next;
  logic [AW-1:0]       abs_q, abs_d, abs_next;
  logic [FIELD_W-1:0]  max_q, max_d, max_next;
  logic [2*RW-1:0]     rad_q, rad_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [RW-1:0]       root_q, root_d;
  logic [ITW-1:0]      it_q, it_d;
  logic                sovf_q, sovf_d;
  logic                ovld_q, ovld_d;
  logic [DIST_W-1:0]   odist_q, odist_d;
  logic                oovf_q, oovf_d;

  logic [2*FIELD_W-1:0] sq_term;
  logic                 out_free;
  logic                 pop;
  logic [REM_W+1:0]     rem_t, trial;
  logic [SQ_CW-1:0]     root_x;
  logic [AB_CW-1:0]     abs_x;
  logic [DIST_W-1:0]    root_sat, abs_sat;

  assign out_free = ~ovld_q | out_ready_i;
  assign pop      = item_valid_i & (state_q == ST_RUN) & (~item_i.last | out_free);
  assign pop_o    = pop;

  assign sq_term  = item_i.diff * item_i.diff;
  assign sq_next  = item_i.keep ? sq_q + SW'(sq_term) : sq_q;
  assign abs_next = item_i.keep ? abs_q + AW'(item_i.diff) : abs_q;
  assign max_next = (item_i.keep && item_i.diff > max_q) ? item_i.diff : max_q;

  assign rem_t = {rem_q, rad_q[2*RW-1 -: 2]};
  assign trial = (REM_W+2)'({root_q, 2'b01});

  assign root_x   = SQ_CW'(root_q);
  assign root_sat = (root_x > SQ_CW'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_x);
  assign abs_x    = AB_CW'(abs_next);
  assign abs_sat  = (abs_x > AB_CW'(DIST_MAX)) ? DIST_MAX : DIST_W'(abs_x);

  always_comb begin
    state_d = state_q;
    sq_d    = sq_q;
    abs_d   = abs_q;
    max_d   = max_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    it_d    = it_q;
    sovf_d  = sovf_q;
    ovld_d  = ovld_q & ~out_ready_i;
    odist_d = odist_q;
    oovf_d  = oovf_q;
    case (state_q)
      ST_RUN: begin
        if (pop) begin
          if (!item_i.last) begin
            sq_d  = sq_next;
            abs_d = abs_next;
            max_d = max_next;
          end else begin
            sq_d  = '0;
            abs_d = '0;
            max_d = '0;
            case (metric_i)
              MET_EUCLID: begin
                rad_d   = (2*RW)'(sq_next);
                rem_d   = '0;
                root_d  = '0;
                it_d    = ITW'(RW);
                sovf_d  = item_i.ovf;
                state_d = ST_SQRT;
              end
              MET_MANHATTAN: begin
                ovld_d  = 1'b1;
                odist_d = abs_sat;
                oovf_d  = item_i.ovf;
              end
              default: begin
                ovld_d  = 1'b1;
                odist_d = DIST_W'(max_next);
                oovf_d  = item_i.ovf;
              end
            endcase
          end
        end
      end
      ST_SQRT: begin
        rad_d = rad_q << 2;
        if (rem_t >= trial) begin
          rem_d  = REM_W'(rem_t - trial);
          root_d = {root_q[RW-2:0], 1'b1};
        end else begin
          rem_d  = REM_W'(rem_t);
          root_d = {root_q[RW-2:0], 1'b0};
        end
        it_d = it_q - ITW'(1);
        if (it_q == ITW'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          odist_d = root_sat;
          oovf_d  = sovf_q;
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      sq_q    <= '0;
      abs_q   <= '0;
      max_q   <= '0;
      it_q    <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sq_q    <= sq_d;
      abs_q   <= abs_d;
      max_q   <= max_d;
      it_q    <= it_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    sovf_q  <= sovf_d;
    odist_q <= odist_d;
    oovf_q  <= oovf_d;
  end

  assign out_valid_o = ovld_q;
  assign distance_o  = odist_q;
  assign overflow_o  = oovf_q;

endmodule
